FILE: rtl/framebuffer_dirty_rect_tracker_macros.svh
// Assertion macros for the dirty-rectangle tracker checker.
// Used by rtl/fbdrt_checker.sv; needs nothing else.
`ifndef FRAMEBUFFER_DIRTY_RECT_TRACKER_MACROS_SVH
`define FRAMEBUFFER_DIRTY_RECT_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FBDRT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FBDRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fbdrt_pkg.sv
// Shared types and constants for the framebuffer dirty-rectangle tracker.
// No dependencies; imported by every module of the block.
package fbdrt_pkg;

    localparam int MAX_DIM       = 1024;
    localparam int DIM_W         = 11;   // screen size registers
    localparam int COORD_W       = 10;   // box coordinates
    localparam int SCOORD_W      = 17;   // signed working coordinates
    localparam int RECT_W        = 16;
    localparam int OFF_W         = 22;
    localparam int LEN_W         = 16;
    localparam int BYTE_SHIFT    = 2;    // four bytes per pixel
    localparam int PIX_W         = OFF_W - BYTE_SHIFT;
    localparam int QUO_W         = 10;   // quotient bits, row below MAX_DIM
    localparam int AREA_W        = 21;
    localparam int CFG_IDX_W     = 2;
    localparam int RESET_WIDTH   = 400;
    localparam int RESET_HEIGHT  = 300;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_SYNC  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_CHECK,
        ST_DIV_S,
        ST_DIV_E,
        ST_MERGE,
        ST_AREA,
        ST_REPORT
    } fsm_state_t;

    typedef struct packed {
        logic             start;
        logic [PIX_W-1:0] dividend;
        logic [DIM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quotient;
        logic [COORD_W-1:0] remainder;
    } div_rsp_t;

    // Zero acts as one, anything above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: rtl/fbdrt_div.sv
// Restoring divider, one quotient bit per cycle, for pixel index by width.
// Depends on fbdrt_pkg.
module fbdrt_div
    import fbdrt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [PIX_W-1:0] rem_reg, rem_next;
    logic [PIX_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [PIX_W:0]   diff;

    always_comb begin
        diff      = {1'b0, rem_reg} - {1'b0, dsh_reg};
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next = req.dividend;
            dsh_next = PIX_W'({req.divisor, {(QUO_W-1){1'b0}}});
            quo_next = '0;
            cnt_next = CNT_W'(QUO_W);
        end else if (cnt_reg != '0) begin
            // subtract when the shifted divisor fits
            if (!diff[PIX_W]) begin
                rem_next = diff[PIX_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[COORD_W-1:0];

endmodule

FILE: rtl/framebuffer_dirty_rect_tracker.sv
// Top level of the framebuffer dirty-rectangle tracker: sequencer, box state,
// shared multiplier and output register. Depends on fbdrt_pkg and fbdrt_div.
//
//  channel | ports                         | direction | transfer when
//  --------+-------------------------------+-----------+----------------------
//  input   | s_valid/s_ready, s_* fields   | in        | s_valid && s_ready
//  result  | m_valid/m_ready, m_* fields   | out       | m_valid && m_ready
//  config  | cfg_we, cfg_index, cfg_wdata  | in        | cfg_we
//
// A framebuffer write holds s_ready low after its transfer while two 10-step
// restoring divisions (start and end pixel by width) run one after the other
// through the single shared divider. An ignored write, a rectangle mark, a
// frame sync or an unused code skips the divisions.
// Reset is synchronous and active low; it restores 400 x 300 and a clean box,
// with no clearing pass. s_ready is low from a transfer until its result is
// loaded; an untaken result holds the sequencer in its report step.
module framebuffer_dirty_rect_tracker
    import fbdrt_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DIM_W-1:0]           cfg_wdata,
    // input items
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic [OFF_W-1:0]           s_byte_offset,
    input  logic [LEN_W-1:0]           s_write_length,
    input  logic                       s_write_flag,
    input  logic signed [RECT_W-1:0]   s_rect_left,
    input  logic signed [RECT_W-1:0]   s_rect_top,
    input  logic signed [RECT_W-1:0]   s_rect_right,
    input  logic signed [RECT_W-1:0]   s_rect_bottom,
    // results
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_dirty,
    output logic [COORD_W-1:0]         m_box_left,
    output logic [COORD_W-1:0]         m_box_top,
    output logic [COORD_W-1:0]         m_box_right,
    output logic [COORD_W-1:0]         m_box_bottom,
    output logic [AREA_W-1:0]          m_box_area
);

    // ------------------------------------------------------------------
    // Screen size registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] eff_w, eff_h, w_m1, h_m1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(RESET_WIDTH);
            height_reg <= DIM_W'(RESET_HEIGHT);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_wdata;
                REG_HEIGHT: height_reg <= cfg_wdata;
                default: ;  // writes beyond the list are dropped
            endcase
        end
    end

    assign eff_w = eff_dim(width_reg);
    assign eff_h = eff_dim(height_reg);
    assign w_m1  = eff_w - DIM_W'(1);
    assign h_m1  = eff_h - DIM_W'(1);

    // ------------------------------------------------------------------
    // Captured item
    // ------------------------------------------------------------------
    logic                     s_xfer;
    logic [1:0]               op_reg;
    logic [OFF_W-1:0]         off_reg;
    logic [LEN_W-1:0]         len_reg;
    logic                     wr_reg;
    logic signed [RECT_W-1:0] left_reg, top_reg, right_reg, bottom_reg;

    assign s_xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg     <= s_op;
            off_reg    <= s_byte_offset;
            len_reg    <= s_write_length;
            wr_reg     <= s_write_flag;
            left_reg   <= s_rect_left;
            top_reg    <= s_rect_top;
            right_reg  <= s_rect_right;
            bottom_reg <= s_rect_bottom;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    fsm_state_t state_reg, state_next;

    logic out_free;
    logic ignore_wr;
    logic div_start;
    logic load_start, load_end, merge_en, report_en, prod_en, mul_size;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    priority if (s_op == OP_WRITE) begin
                        state_next = ST_SIZE;
                    end else if (s_op == OP_MARK) begin
                        state_next = ST_MERGE;
                    end else begin
                        state_next = ST_AREA;
                    end
                end
            end
            ST_SIZE:   state_next = ST_CHECK;
            ST_CHECK:  state_next = ignore_wr ? ST_AREA : ST_DIV_S;
            ST_DIV_S:  if (div_rsp.done) state_next = ST_DIV_E;
            ST_DIV_E:  if (div_rsp.done) state_next = ST_MERGE;
            ST_MERGE:  state_next = ST_AREA;
            ST_AREA:   state_next = ST_REPORT;
            ST_REPORT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        div_start  = 1'b0;
        load_start = 1'b0;
        load_end   = 1'b0;
        merge_en   = 1'b0;
        report_en  = 1'b0;
        prod_en    = 1'b0;
        mul_size   = 1'b0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_SIZE: begin
                prod_en  = 1'b1;
                mul_size = 1'b1;
            end
            ST_CHECK:  div_start = !ignore_wr;
            ST_DIV_S: begin
                // chain the end-pixel division straight after the start one
                load_start = div_rsp.done;
                div_start  = div_rsp.done;
            end
            ST_DIV_E:  load_end  = div_rsp.done;
            ST_MERGE:  merge_en  = 1'b1;
            ST_AREA:   prod_en   = 1'b1;
            ST_REPORT: report_en = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: screen pixel count, then box area
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   span_w, span_h, mul_a, mul_b;
    logic [2*DIM_W-1:0] mul_p;
    logic [AREA_W-1:0]  prod_reg;

    logic                 dirty_reg, dirty_next;
    logic [COORD_W-1:0]   min_col_reg, min_col_next, min_row_reg, min_row_next;
    logic [COORD_W-1:0]   max_col_reg, max_col_next, max_row_reg, max_row_next;

    assign span_w = ({1'b0, max_col_reg} - {1'b0, min_col_reg}) + DIM_W'(1);
    assign span_h = ({1'b0, max_row_reg} - {1'b0, min_row_reg}) + DIM_W'(1);
    assign mul_a  = mul_size ? eff_w : span_w;
    assign mul_b  = mul_size ? eff_h : span_h;
    assign mul_p  = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            prod_reg <= mul_p[AREA_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Write span: start pixel, clipped end pixel, ignore test
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  sp_pix, ep_clip, ep_reg;
    logic [OFF_W:0]    last_byte;
    logic [AREA_W-1:0] ep_raw, lim;

    assign sp_pix    = off_reg[OFF_W-1:BYTE_SHIFT];
    assign last_byte = {1'b0, off_reg} + (OFF_W+1)'(len_reg) - (OFF_W+1)'(1);
    assign ep_raw    = last_byte[OFF_W:BYTE_SHIFT];
    assign lim       = prod_reg - AREA_W'(1);
    assign ep_clip   = (ep_raw > lim) ? lim[PIX_W-1:0] : ep_raw[PIX_W-1:0];
    // drop reads, empty writes and writes starting past the framebuffer
    assign ignore_wr = !wr_reg || (len_reg == '0) || ({1'b0, sp_pix} >= prod_reg);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHECK) begin
            ep_reg <= ep_clip;
        end
    end

    assign div_req.start    = div_start;
    assign div_req.dividend = (state_reg == ST_CHECK) ? sp_pix : ep_reg;
    assign div_req.divisor  = eff_w;

    fbdrt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic [COORD_W-1:0] sr_reg, sc_reg, er_reg, ec_reg;

    always_ff @(posedge aclk) begin
        if (load_start) begin
            sr_reg <= div_rsp.quotient;
            sc_reg <= div_rsp.remainder;
        end
        if (load_end) begin
            er_reg <= div_rsp.quotient;
            ec_reg <= div_rsp.remainder;
        end
    end

    // ------------------------------------------------------------------
    // Merge: pick the corners, clamp to the screen, grow the box
    // ------------------------------------------------------------------
    logic signed [SCOORD_W-1:0] x0, y0, x1, y1;
    logic signed [SCOORD_W-1:0] x0c, y0c, x1c, y1c;
    logic signed [SCOORD_W-1:0] wlim, hlim, wmax, hmax;
    logic                       rect_empty;
    logic [COORD_W-1:0]         nx0, ny0, nx1, ny1;

    assign wlim = $signed(SCOORD_W'(eff_w));
    assign hlim = $signed(SCOORD_W'(eff_h));
    assign wmax = $signed(SCOORD_W'(w_m1));
    assign hmax = $signed(SCOORD_W'(h_m1));

    always_comb begin
        if (op_reg == OP_MARK) begin
            x0 = SCOORD_W'(left_reg);
            y0 = SCOORD_W'(top_reg);
            x1 = SCOORD_W'(right_reg);
            y1 = SCOORD_W'(bottom_reg);
        end else if (sr_reg == er_reg) begin
            // span inside one row: its own columns
            x0 = $signed(SCOORD_W'(sc_reg));
            y0 = $signed(SCOORD_W'(sr_reg));
            x1 = $signed(SCOORD_W'(ec_reg));
            y1 = $signed(SCOORD_W'(er_reg));
        end else begin
            // span over several rows: full width
            x0 = '0;
            y0 = $signed(SCOORD_W'(sr_reg));
            x1 = wmax;
            y1 = $signed(SCOORD_W'(er_reg));
        end
        x0c        = x0[SCOORD_W-1] ? '0 : x0;
        y0c        = y0[SCOORD_W-1] ? '0 : y0;
        x1c        = (x1 >= wlim) ? wmax : x1;
        y1c        = (y1 >= hlim) ? hmax : y1;
        rect_empty = (x0c > x1c) || (y0c > y1c);
        nx0        = x0c[COORD_W-1:0];
        ny0        = y0c[COORD_W-1:0];
        nx1        = x1c[COORD_W-1:0];
        ny1        = y1c[COORD_W-1:0];
    end

    always_comb begin
        dirty_next   = dirty_reg;
        min_col_next = min_col_reg;
        min_row_next = min_row_reg;
        max_col_next = max_col_reg;
        max_row_next = max_row_reg;
        if (merge_en && !rect_empty) begin
            if (!dirty_reg) begin
                dirty_next   = 1'b1;
                min_col_next = nx0;
                min_row_next = ny0;
                max_col_next = nx1;
                max_row_next = ny1;
            end else begin
                if (nx0 < min_col_reg) min_col_next = nx0;
                if (ny0 < min_row_reg) min_row_next = ny0;
                if (nx1 > max_col_reg) max_col_next = nx1;
                if (ny1 > max_row_reg) max_row_next = ny1;
            end
        end
        // a frame sync reports first, then clears
        if (report_en && (op_reg == OP_SYNC)) begin
            dirty_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg   <= 1'b0;
            min_col_reg <= '0;
            min_row_reg <= '0;
            max_col_reg <= '0;
            max_row_reg <= '0;
        end else begin
            dirty_reg   <= dirty_next;
            min_col_reg <= min_col_next;
            min_row_reg <= min_row_next;
            max_col_reg <= max_col_next;
            max_row_reg <= max_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the result until its transfer
    // ------------------------------------------------------------------
    logic m_valid_reg, m_valid_next;
    logic                 dirty_out_reg;
    logic [COORD_W-1:0]   left_out_reg, top_out_reg, right_out_reg, bottom_out_reg;
    logic [AREA_W-1:0]    area_out_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (report_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (report_en) begin
            // a clean box reports all zero
            dirty_out_reg  <= dirty_reg;
            left_out_reg   <= dirty_reg ? min_col_reg : '0;
            top_out_reg    <= dirty_reg ? min_row_reg : '0;
            right_out_reg  <= dirty_reg ? max_col_reg : '0;
            bottom_out_reg <= dirty_reg ? max_row_reg : '0;
            area_out_reg   <= dirty_reg ? prod_reg    : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_dirty      = dirty_out_reg;
    assign m_box_left   = left_out_reg;
    assign m_box_top    = top_out_reg;
    assign m_box_right  = right_out_reg;
    assign m_box_bottom = bottom_out_reg;
    assign m_box_area   = area_out_reg;

endmodule

FILE: rtl/fbdrt_checker.sv
// Port-level checks for the dirty-rectangle tracker, bound to the top level.
// Depends on fbdrt_pkg and framebuffer_dirty_rect_tracker_macros.svh.
`include "framebuffer_dirty_rect_tracker_macros.svh"

module fbdrt_checker
    import fbdrt_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_dirty,
    input logic [COORD_W-1:0]       m_box_left,
    input logic [COORD_W-1:0]       m_box_top,
    input logic [COORD_W-1:0]       m_box_right,
    input logic [COORD_W-1:0]       m_box_bottom,
    input logic [AREA_W-1:0]        m_box_area
);

    logic [4*COORD_W+AREA_W:0] out_word;
    logic                      clean_zero;
    logic                      box_ordered;

    assign out_word = {m_dirty, m_box_left, m_box_top, m_box_right, m_box_bottom,
                       m_box_area};
    assign clean_zero = (m_box_left == '0) && (m_box_top == '0) &&
                        (m_box_right == '0) && (m_box_bottom == '0) &&
                        (m_box_area == '0);
    assign box_ordered = (m_box_left <= m_box_right) && (m_box_top <= m_box_bottom) &&
                         (m_box_area != '0);

    `FBDRT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after transfer")
    `FBDRT_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_word), "result dropped or changed")
    `FBDRT_ASSERT_NOW(a_clean_box, aclk, aresetn, m_valid && !m_dirty, clean_zero, "clean box not zero")
    `FBDRT_ASSERT_NOW(a_dirty_box, aclk, aresetn, m_valid && m_dirty, box_ordered, "dirty box malformed")

endmodule

bind framebuffer_dirty_rect_tracker fbdrt_checker u_checker (.*);
